### src/lifeg_pkg.sv
// ----------------------------------------------------------------------------
// lifeg_pkg
// Shared types and constants for the Life generation stream block.
// ----------------------------------------------------------------------------
package lifeg_pkg;

    localparam int WIDTH_BITS  = 6;    // board_width register
    localparam int HEIGHT_BITS = 16;   // board_height register
    localparam int CELL_BITS   = 8;    // age field on the stream ports
    localparam int ROW_SLOTS   = 3;    // rows held in the line store
    localparam int SLOT_W      = 2;
    localparam int NBR_W       = 4;    // live neighbor count 0..8

    localparam logic [NBR_W-1:0] BIRTH_COUNT = 4'd3;
    localparam logic [NBR_W-1:0] STAY_COUNT  = 4'd2;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 6'd32;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd32;

    // register select, paddr[2]
    localparam logic REG_BOARD_WIDTH  = 1'b0;
    localparam logic REG_BOARD_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        ST_STREAM,   // taking cells from the input
        ST_EARLY,    // extra result for first cell of last row
        ST_FLUSH,    // dead row below the board, one column a cycle unless stalled
        ST_FINAL     // last cell of the board
    } t_state;

    // per-item control carried from issue to the window stage
    typedef struct packed {
        logic col_zero;    // column 0: right side of window is off board
        logic top_ok;      // row above-above exists
        logic mid_ok;      // row above exists
        logic bot_ok;      // incoming row is on the board
        logic emit;        // item produces a result
        logic early;       // compute first cell of last row, no shift
        logic last_run;    // final result for the input item
        logic end_frame;   // result is the board's last cell
    } t_s1_ctl;

endpackage

### src/lifeg_line_store.sv
// ----------------------------------------------------------------------------
// lifeg_line_store
// Three rotating row slots of cell ages; one write and two registered reads
// per cycle, all at the same column.
// ----------------------------------------------------------------------------
module lifeg_line_store
    import lifeg_pkg::*;
#(
    parameter int MAX_WIDTH = 63,
    parameter int AGE_BITS  = 8
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [SLOT_W-1:0]            i_wr_slot,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_col,
    input  logic [AGE_BITS-1:0]          i_wr_data,
    input  logic                         i_rd_en,
    input  logic [SLOT_W-1:0]            i_top_slot,
    input  logic [SLOT_W-1:0]            i_mid_slot,
    output logic [AGE_BITS-1:0]          o_top,
    output logic [AGE_BITS-1:0]          o_mid
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int DEPTH  = ROW_SLOTS * MAX_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [AGE_BITS-1:0] r_mem [DEPTH];
    logic [AGE_BITS-1:0] r_top;
    logic [AGE_BITS-1:0] r_mid;

    logic [ADDR_W-1:0] w_wr_addr;
    logic [ADDR_W-1:0] w_top_addr;
    logic [ADDR_W-1:0] w_mid_addr;

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] slot,
                                                     input logic [COL_W-1:0]  col);
        return ADDR_W'(32'(slot) * 32'(MAX_WIDTH) + 32'(col));
    endfunction

    assign w_wr_addr  = slot_addr(i_wr_slot, i_col);
    assign w_top_addr = slot_addr(i_top_slot, i_col);
    assign w_mid_addr = slot_addr(i_mid_slot, i_col);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[w_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_top <= r_mem[w_top_addr];
            r_mid <= r_mem[w_mid_addr];
        end
    end

    assign o_top = r_top;
    assign o_mid = r_mid;

endmodule

### src/lifeg_window.sv
// ----------------------------------------------------------------------------
// lifeg_window
// Two-column window registers plus the incoming column form the 3x3
// neighborhood; counts live neighbors and applies the aging rule.
// ----------------------------------------------------------------------------
module lifeg_window
    import lifeg_pkg::*;
#(
    parameter int AGE_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_shift,
    input  t_s1_ctl             i_ctl,
    input  logic [AGE_BITS-1:0] i_top,
    input  logic [AGE_BITS-1:0] i_mid,
    input  logic [AGE_BITS-1:0] i_bot,
    output logic [AGE_BITS-1:0] o_next_age,
    output logic                o_sat
);

    // left and middle columns: top, mid, bottom rows
    logic [AGE_BITS-1:0] r_lt, r_lm, r_lb;
    logic [AGE_BITS-1:0] r_mt, r_mm, r_mb;

    logic [AGE_BITS-1:0] w_in_t, w_in_m, w_in_b;
    logic [AGE_BITS-1:0] w_rt, w_rm, w_rb;
    logic [AGE_BITS-1:0] w_center;
    logic [7:0]          w_nbr;
    logic [NBR_W-1:0]    w_count;

    assign w_in_t = i_ctl.top_ok ? i_top : '0;
    assign w_in_m = i_ctl.mid_ok ? i_mid : '0;
    assign w_in_b = i_ctl.bot_ok ? i_bot : '0;

    // at column 0 the cell being finished is the row's last one
    assign w_rt = i_ctl.col_zero ? '0 : w_in_t;
    assign w_rm = i_ctl.col_zero ? '0 : w_in_m;
    assign w_rb = i_ctl.col_zero ? '0 : w_in_b;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            if (i_ctl.col_zero) begin
                r_lt <= '0;
                r_lm <= '0;
                r_lb <= '0;
            end else begin
                r_lt <= r_mt;
                r_lm <= r_mm;
                r_lb <= r_mb;
            end
            r_mt <= w_in_t;
            r_mm <= w_in_m;
            r_mb <= w_in_b;
        end
    end

    always_comb begin
        if (i_ctl.early) begin
            // first cell of the last row sits at bottom of left column
            w_center = r_lb;
            w_nbr    = {|r_lm, |r_mm, |r_mb, 5'b0};
        end else begin
            w_center = r_mm;
            w_nbr    = {|r_lt, |r_lm, |r_lb, |r_mt, |r_mb, |w_rt, |w_rm, |w_rb};
        end
    end

    always_comb begin
        w_count = '0;
        for (int i = 0; i < 8; i++) begin
            w_count = w_count + NBR_W'(w_nbr[i]);
        end
    end

    always_comb begin
        o_next_age = '0;
        o_sat      = 1'b0;
        if (w_center == '0) begin
            if (w_count == BIRTH_COUNT) begin
                o_next_age = AGE_BITS'(1);
            end
        end else if (w_count == STAY_COUNT || w_count == BIRTH_COUNT) begin
            if (&w_center) begin
                o_next_age = w_center;
                o_sat      = 1'b1;
            end else begin
                o_next_age = w_center + AGE_BITS'(1);
            end
        end
    end

endmodule

### src/life_automaton_generation_step.sv
// ----------------------------------------------------------------------------
// life_automaton_generation_step
// One generation of Life with cell ages over a raster stream of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Cell ages enter on the s_axis channel in raster order, one item per
//   cycle while ready is high. Results leave on m_axis in raster order,
//   each one row plus one cell behind the input; tlast marks the final
//   result of an input item, tuser[1] marks the board's last cell.
//   Path: the input that completes a neighborhood goes through the line
//   store read (window stage), then the result register, before leaving.
//   Throughput: one cell per cycle while the output is not held. Per frame
//   the input pauses for an extra result after the second cell of the last
//   row (boards of 2+ rows and 3+ columns), and after the last cell while
//   the row below the board is swept from the line store.
//   Board size is set over APB (width at 0x0, height at 0x4); write it only while idle,
//   which the block itself does not enforce. A write restarts the frame position.
//   Reset: 32x32 board, frame position zero; line store contents are not
//   cleared and need none, every read is of a row written this frame.
//   Stall: a held output register backs up the window stage; input ready
//   drops once that stage is full.
// ----------------------------------------------------------------------------
module life_automaton_generation_step
    import lifeg_pkg::*;
#(
    parameter int MAX_WIDTH = 63,
    parameter int AGE_BITS  = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [CELL_BITS-1:0] s_axis_tdata,   // [7:0] cell_age
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [CELL_BITS-1:0] m_axis_tdata,   // [7:0] next_age
    output logic                 m_axis_tlast,   // last_of_run
    output logic [1:0]           m_axis_tuser,   // [0] age_saturated, [1] end_of_frame
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int UW    = $clog2(MAX_WIDTH + 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(ROW_SLOTS - 1);

    // configuration
    logic [WIDTH_BITS-1:0]  r_board_width;
    logic [HEIGHT_BITS-1:0] r_board_height;
    logic                   w_cfg_wr;

    logic [UW-1:0]          w_used_w;
    logic [COL_W-1:0]       w_last_col;
    logic [HEIGHT_BITS-1:0] w_used_h;
    logic [HEIGHT_BITS-1:0] w_last_row;
    logic                   w_early_ok;
    logic                   w_tall;

    // sequencer
    t_state                 r_state, n_state;
    logic [COL_W-1:0]       r_col, n_col;
    logic [HEIGHT_BITS-1:0] r_row, n_row;
    logic [SLOT_W-1:0]      r_slot, n_slot;
    logic                   w_issue;
    logic                   w_accept;
    logic                   w_is_last;
    logic                   w_early_next;
    t_s1_ctl                w_a_ctl;

    // window stage
    logic                   r_s1_valid;
    t_s1_ctl                r_s1_ctl;
    logic [AGE_BITS-1:0]    r_s1_age;
    logic                   w_s1_free;
    logic                   w_s1_move;
    logic [AGE_BITS-1:0]    w_q_top;
    logic [AGE_BITS-1:0]    w_q_mid;
    logic [AGE_BITS-1:0]    w_next_age;
    logic                   w_sat;

    // output register
    logic                   r_o_valid;
    logic [CELL_BITS-1:0]   r_o_age;
    logic                   r_o_sat;
    logic                   r_o_last;
    logic                   r_o_end;
    logic                   w_out_free;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_LAST) ? '0 : s + SLOT_W'(1);
    endfunction

    function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
        return (s == '0) ? SLOT_LAST : s - SLOT_W'(1);
    endfunction

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board_width  <= WIDTH_RESET;
            r_board_height <= HEIGHT_RESET;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_BOARD_WIDTH:  r_board_width  <= pwdata[WIDTH_BITS-1:0];
                REG_BOARD_HEIGHT: r_board_height <= pwdata[HEIGHT_BITS-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_BOARD_WIDTH:  prdata = 32'(r_board_width);
            REG_BOARD_HEIGHT: prdata = 32'(r_board_height);
        endcase
    end

    always_comb begin
        if (r_board_width == '0) begin
            w_used_w = UW'(1);
        end else if (32'(r_board_width) > 32'(MAX_WIDTH)) begin
            w_used_w = UW'(MAX_WIDTH);
        end else begin
            w_used_w = UW'(r_board_width);
        end
    end

    assign w_last_col = COL_W'(w_used_w - UW'(1));
    assign w_used_h   = (r_board_height == '0) ? HEIGHT_BITS'(1) : r_board_height;
    assign w_last_row = w_used_h - HEIGHT_BITS'(1);
    assign w_tall     = w_used_h >= HEIGHT_BITS'(2);
    assign w_early_ok = w_tall && (w_used_w >= UW'(3));

    // ---------------- issue / sequencer ----------------
    assign w_out_free = !r_o_valid || m_axis_tready;
    assign w_s1_move  = r_s1_valid && (!r_s1_ctl.emit || w_out_free);
    assign w_s1_free  = !r_s1_valid || w_s1_move;

    assign s_axis_tready = (r_state == ST_STREAM) && w_s1_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_is_last    = (r_row == w_last_row) && (r_col == w_last_col);
    assign w_early_next = w_early_ok && (r_row == w_last_row) && (r_col == COL_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_STREAM;
            r_col   <= '0;
            r_row   <= '0;
            r_slot  <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_slot  <= n_slot;
        end
    end

    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_row   = r_row;
        n_slot  = r_slot;
        w_issue = 1'b0;
        w_a_ctl = '0;
        unique case (r_state)
            ST_STREAM: begin
                w_issue          = w_accept;
                w_a_ctl.col_zero = (r_col == '0);
                w_a_ctl.top_ok   = r_row >= HEIGHT_BITS'(2);
                w_a_ctl.mid_ok   = (r_row != '0);
                w_a_ctl.bot_ok   = 1'b1;
                w_a_ctl.emit     = (r_row >= HEIGHT_BITS'(2)) ||
                                   ((r_row == HEIGHT_BITS'(1)) && (r_col != '0));
                w_a_ctl.last_run = w_a_ctl.emit && !w_is_last && !w_early_next;
                if (w_accept) begin
                    if (w_is_last) begin
                        n_state = ST_FLUSH;
                        n_col   = '0;
                        n_row   = '0;
                        n_slot  = slot_inc(r_slot);
                    end else if (r_col == w_last_col) begin
                        n_col  = '0;
                        n_row  = r_row + HEIGHT_BITS'(1);
                        n_slot = slot_inc(r_slot);
                    end else begin
                        n_col = r_col + COL_W'(1);
                        if (w_early_next) begin
                            n_state = ST_EARLY;
                        end
                    end
                end
            end
            ST_EARLY: begin
                w_issue          = w_s1_free;
                w_a_ctl.emit     = 1'b1;
                w_a_ctl.early    = 1'b1;
                w_a_ctl.last_run = 1'b1;
                if (w_s1_free) begin
                    n_state = ST_STREAM;
                end
            end
            ST_FLUSH: begin
                // dead row below the board; the early cell is not repeated
                w_issue          = w_s1_free;
                w_a_ctl.col_zero = (r_col == '0);
                w_a_ctl.top_ok   = w_tall;
                w_a_ctl.mid_ok   = 1'b1;
                w_a_ctl.emit     = (w_tall || (r_col != '0)) &&
                                   !(w_early_ok && (r_col == COL_W'(1)));
                if (w_s1_free) begin
                    if (r_col == w_last_col) begin
                        n_state = ST_FINAL;
                        n_col   = '0;
                    end else begin
                        n_col = r_col + COL_W'(1);
                    end
                end
            end
            ST_FINAL: begin
                w_issue           = w_s1_free;
                w_a_ctl.col_zero  = 1'b1;
                w_a_ctl.emit      = 1'b1;
                w_a_ctl.last_run  = 1'b1;
                w_a_ctl.end_frame = 1'b1;
                if (w_s1_free) begin
                    n_state = ST_STREAM;
                end
            end
            default: begin
                n_state = ST_STREAM;
            end
        endcase
        if (w_cfg_wr) begin
            n_col = '0;
            n_row = '0;
        end
    end

    lifeg_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .AGE_BITS  (AGE_BITS)
    ) u_line_store (
        .i_clk      (i_clk),
        .i_wr_en    (w_accept),
        .i_wr_slot  (r_slot),
        .i_col      (r_col),
        .i_wr_data  (AGE_BITS'(s_axis_tdata)),
        .i_rd_en    (w_issue),
        .i_top_slot (slot_inc(r_slot)),
        .i_mid_slot (slot_dec(r_slot)),
        .o_top      (w_q_top),
        .o_mid      (w_q_mid)
    );

    // ---------------- window stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_free) begin
            r_s1_valid <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_free && w_issue) begin
            r_s1_ctl <= w_a_ctl;
            r_s1_age <= AGE_BITS'(s_axis_tdata);
        end
    end

    lifeg_window #(
        .AGE_BITS (AGE_BITS)
    ) u_window (
        .i_clk      (i_clk),
        .i_shift    (w_s1_move && !r_s1_ctl.early),
        .i_ctl      (r_s1_ctl),
        .i_top      (w_q_top),
        .i_mid      (w_q_mid),
        .i_bot      (r_s1_age),
        .o_next_age (w_next_age),
        .o_sat      (w_sat)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_free) begin
            r_o_valid <= r_s1_valid && r_s1_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_s1_valid && r_s1_ctl.emit) begin
            r_o_age  <= CELL_BITS'(w_next_age);
            r_o_sat  <= w_sat;
            r_o_last <= r_s1_ctl.last_run;
            r_o_end  <= r_s1_ctl.end_frame;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_age;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tuser  = {r_o_end, r_o_sat};

    // ---------------- assertions ----------------
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
        else $error("end of frame result without tlast");

    a_flush_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_is_last && !w_cfg_wr |=> r_state == ST_FLUSH)
        else $error("last cell did not start the flush");

    a_col_in_board: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        UW'(r_col) < w_used_w)
        else $error("column position beyond board width");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_LAST)
        else $error("line store slot out of range");

endmodule

### tb/tb_life_automaton_generation_step.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_life_automaton_generation_step
// Streams cell ages over boards of many sizes, predicts every next-generation
// result with an in-bench model of the aging Life rule, and checks each result
// field by field in order. Board size is changed over APB, sometimes mid-frame.
// ----------------------------------------------------------------------------
module tb_life_automaton_generation_step;
    import lifeg_pkg::*;

    localparam int MAX_GAP       = 14;
    localparam int LONG_HOLD     = 200;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 24;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_CELLS  = 130;
    localparam int STORE_COLS    = 63;
    localparam int MAX_AGE       = 255;

    typedef struct packed {
        logic [CELL_BITS-1:0] next_age;
        logic                 saturated;
        logic                 run_end;
        logic                 frame_end;
    } t_cell_outcome;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [CELL_BITS-1:0] s_axis_tdata = '0;   // [7:0] cell_age
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [CELL_BITS-1:0] m_axis_tdata;        // [7:0] next_age
    logic                 m_axis_tlast;
    logic [1:0]           m_axis_tuser;        // [0] age_saturated, [1] end_of_frame
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [2:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    life_automaton_generation_step dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // board model: four row slots indexed by row mod 4
    logic [CELL_BITS-1:0]   age_rows [0:3][0:STORE_COLS-1];
    logic [WIDTH_BITS-1:0]  board_width;
    logic [HEIGHT_BITS-1:0] board_height;
    int                     scan_row;
    int                     scan_col;

    logic [CELL_BITS-1:0] pending_ages [$];
    t_cell_outcome        expected_cells [$];

    int error_count = 0;
    int cycle_count = 0;
    int src_gap_max = 0;
    int sink_gap_max = 0;
    int src_wait = 0;
    int sink_wait = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    task automatic flag_error(input string msg);
        if (error_count < 100)
            $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic t_cell_outcome evolve_cell(input int rr, input int cc,
                                                  input int w, input int h);
        t_cell_outcome res;
        int            live;
        int            nr;
        int            nc;
        int            cur;
        live = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                nr = rr + dr;
                nc = cc + dc;
                if (!(dr == 0 && dc == 0) && nr >= 0 && nc >= 0 && nr < h && nc < w)
                    if (age_rows[nr % 4][nc] != 0) live++;
            end
        end
        cur = age_rows[rr % 4][cc];
        res = '0;
        if (cur == 0) begin
            res.next_age = (live == 3) ? 8'd1 : 8'd0;
        end else if (live == 2 || live == 3) begin
            if (cur >= MAX_AGE) begin
                res.next_age  = 8'(MAX_AGE);
                res.saturated = 1'b1;
            end else begin
                res.next_age = 8'(cur + 1);
            end
        end
        res.frame_end = (rr == h - 1) && (cc == w - 1);
        return res;
    endfunction

    function automatic void advance_board(input logic [CELL_BITS-1:0] age);
        t_cell_outcome batch [0:64];
        int            n;
        int            w;
        int            h;
        int            r;
        int            c;
        int            k;
        int            idx;
        bit            last_cell;
        bit            early_ok;
        w = (board_width == 0) ? 1 : int'(board_width);
        h = (board_height == 0) ? 1 : int'(board_height);
        r = scan_row;
        c = scan_col;
        if (r >= h) begin
            r = 0;
            c = 0;
        end
        if (c >= w) c = 0;
        age_rows[r % 4][c] = age;
        k = r * w + c;
        last_cell = (r == h - 1) && (c == w - 1);
        // first cell of the last row leaves early on boards of 2+ rows, 3+ columns
        early_ok = (h >= 2) && (w >= 3);
        n = 0;
        if (!last_cell) begin
            if (k >= w + 1) begin
                batch[n] = evolve_cell((k - w - 1) / w, (k - w - 1) % w, w, h);
                n++;
            end
            if (early_ok && r == h - 1 && c == 1) begin
                batch[n] = evolve_cell(h - 1, 0, w, h);
                n++;
            end
        end else begin
            // frame end flushes everything still owed, minus the early cell
            for (idx = (k >= w + 1) ? k - w - 1 : 0; idx <= k; idx++) begin
                if (!(early_ok && idx == (h - 1) * w)) begin
                    batch[n] = evolve_cell(idx / w, idx % w, w, h);
                    n++;
                end
            end
        end
        if (n > 0) batch[n - 1].run_end = 1'b1;
        for (int i = 0; i < n; i++)
            expected_cells.push_back(batch[i]);
        if (last_cell) begin
            scan_row = 0;
            scan_col = 0;
        end else if (c + 1 >= w) begin
            scan_col = 0;
            scan_row = r + 1;
        end else begin
            scan_col = c + 1;
            scan_row = r;
        end
    endfunction

    function automatic void load_board_register(input logic sel, input logic [31:0] value);
        if (sel == REG_BOARD_WIDTH)
            board_width = value[WIDTH_BITS-1:0];
        else
            board_height = value[HEIGHT_BITS-1:0];
        scan_row = 0;
        scan_col = 0;
    endfunction

    // ------------------------------------------------------------------
    // cell driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_wait      <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                advance_board(s_axis_tdata);
            if (s_axis_tvalid && !s_axis_tready) begin
                // item not taken yet, keep offering it
            end else if (src_wait > 0) begin
                s_axis_tvalid <= 1'b0;
                src_wait      <= src_wait - 1;
            end else if (pending_ages.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_ages.pop_front();
                src_wait      <= $urandom_range(src_gap_max);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result side: long hold-off, per-item ready gaps, checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left   <= 0;
            hold_served <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= LONG_HOLD;
        end
    end

    always @(posedge i_clk) begin : sink_side
        int pause;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_wait     <= 0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
        end else if (m_axis_tready) begin
            if (m_axis_tvalid) begin
                pause = $urandom_range(sink_gap_max);
                sink_wait     <= pause;
                m_axis_tready <= (pause == 0);
            end
        end else if (sink_wait > 0) begin
            sink_wait <= sink_wait - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_cell_outcome want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_cells.size() == 0) begin
                flag_error($sformatf("result with nothing expected: age %0d", m_axis_tdata));
            end else begin
                want = expected_cells.pop_front();
                if (m_axis_tdata !== want.next_age)
                    flag_error($sformatf("next_age %0d, expected %0d",
                                         m_axis_tdata, want.next_age));
                if (m_axis_tuser[0] !== want.saturated)
                    flag_error($sformatf("age_saturated %b, expected %b",
                                         m_axis_tuser[0], want.saturated));
                if (m_axis_tlast !== want.run_end)
                    flag_error($sformatf("last_of_run %b, expected %b",
                                         m_axis_tlast, want.run_end));
                if (m_axis_tuser[1] !== want.frame_end)
                    flag_error($sformatf("end_of_frame %b, expected %b",
                                         m_axis_tuser[1], want.frame_end));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_life_automaton_generation_step: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // APB access and sequencing helpers
    // ------------------------------------------------------------------
    task automatic write_register(input logic sel, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        load_board_register(sel, value);
    endtask

    task automatic read_register(input logic sel, input logic [31:0] want);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {sel, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want)
            flag_error($sformatf("register %0d reads %0h, expected %0h", sel, prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // wait until every item is in and every result is out, then let the
    // pipeline empty of items that owe nothing
    task automatic settle();
        while (pending_ages.size() != 0 || s_axis_tvalid || expected_cells.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_board(input int raw_w, input int raw_h);
        logic [31:0] wv;
        logic [31:0] hv;
        settle();
        // junk above each field must be ignored
        wv = ($urandom() & 32'hFFFF_FFC0) | 32'(raw_w[WIDTH_BITS-1:0]);
        hv = ($urandom() & 32'hFFFF_0000) | 32'(raw_h[HEIGHT_BITS-1:0]);
        write_register(REG_BOARD_WIDTH, wv);
        write_register(REG_BOARD_HEIGHT, hv);
        read_register(REG_BOARD_WIDTH, 32'(raw_w[WIDTH_BITS-1:0]));
        read_register(REG_BOARD_HEIGHT, 32'(raw_h[HEIGHT_BITS-1:0]));
    endtask

    function automatic logic [CELL_BITS-1:0] random_age();
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return '0;
            6:                return 8'd255;
            7:                return 8'd254;
            default:          return 8'($urandom_range(255, 1));
        endcase
    endfunction

    task automatic queue_random_cells(input int count);
        for (int i = 0; i < count; i++)
            pending_ages.push_back(random_age());
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        // blinker with a saturated center; 1x1 via zero sizes; single column;
        // two columns; short wide board with saturation on the top row
        int                   dir_w [5]  = '{3, 0, 1, 2, 4};
        int                   dir_h [5]  = '{3, 0, 3, 3, 2};
        logic [CELL_BITS-1:0] dir_ages [27] = '{
            8'd0,   8'd255, 8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd255, 8'd0,
            8'd200,
            8'd1,   8'd128, 8'd127,
            8'd254, 8'd1,   8'd0,   8'd255, 8'd64,  8'd0,
            8'd255, 8'd255, 8'd0,   8'd3,   8'd255, 8'd0,   8'd2,   8'd0};
        int                   cursor;
        int                   cells;
        int                   raw_w;
        int                   raw_h;
        int                   area;
        int                   count;
        int                   random_cells;

        board_width  = WIDTH_RESET;
        board_height = HEIGHT_RESET;
        scan_row     = 0;
        scan_col     = 0;
        for (int s = 0; s < 4; s++)
            for (int x = 0; x < STORE_COLS; x++)
                age_rows[s][x] = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames
        src_gap_max  <= 3;
        sink_gap_max <= 3;
        cursor = 0;
        for (int f = 0; f < 5; f++) begin
            set_board(dir_w[f], dir_h[f]);
            cells = (dir_w[f] == 0 ? 1 : dir_w[f]) * (dir_h[f] == 0 ? 1 : dir_h[f]);
            for (int i = 0; i < cells; i++) begin
                pending_ages.push_back(dir_ages[cursor]);
                cursor++;
            end
        end

        // tallest board, widest rows: partial frame under a long output stall,
        // then abandoned by the next register write
        src_gap_max  <= 0;
        sink_gap_max <= 0;
        set_board(63, 65535);
        hold_requests <= hold_requests + 1;
        queue_random_cells(2 * 63 + 5);

        // widest two-row frame: the final flush carries the most results
        sink_gap_max <= MAX_GAP;
        set_board(63, 2);
        queue_random_cells(2 * 63);

        random_cells = 0;
        while (random_cells < RANDOM_CELLS) begin
            raw_w = ($urandom_range(11) == 0) ? 0 : $urandom_range(12, 1);
            raw_h = ($urandom_range(11) == 0) ? 0 : $urandom_range(5, 1);
            area  = (raw_w == 0 ? 1 : raw_w) * (raw_h == 0 ? 1 : raw_h);
            src_gap_max  <= ($urandom_range(2) == 0) ? 0 : MAX_GAP;
            sink_gap_max <= ($urandom_range(2) == 0) ? 0 : MAX_GAP;
            set_board(raw_w, raw_h);
            if (area > 1 && $urandom_range(7) == 0)
                count = $urandom_range(area - 1, 1);     // cut short, restarted by next write
            else if ($urandom_range(2) == 0)
                count = 2 * area;                        // two frames back to back
            else
                count = area;
            queue_random_cells(count);
            random_cells += count;
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_cells.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_cells.size()));
        if (error_count == 0)
            $display("tb_life_automaton_generation_step: clean");
        else
            $display("tb_life_automaton_generation_step: errors");
        $finish;
    end

endmodule

### sim.f
src/lifeg_pkg.sv
src/lifeg_line_store.sv
src/lifeg_window.sv
src/life_automaton_generation_step.sv
tb/tb_life_automaton_generation_step.sv
